### rtl/sha1_pkg.sv
// shared types and constants of the sha-1 hash engine
`default_nettype none
package sha1_pkg;

  localparam int unsigned WordW   = 32;
  localparam int unsigned Rounds  = 80;
  localparam int unsigned RoundW  = 7;
  localparam int unsigned Words   = 5;

  // initial chaining value
  localparam logic [WordW-1:0] Iv0 = 32'h6745_2301;
  localparam logic [WordW-1:0] Iv1 = 32'hEFCD_AB89;
  localparam logic [WordW-1:0] Iv2 = 32'h98BA_DCFE;
  localparam logic [WordW-1:0] Iv3 = 32'h1032_5476;
  localparam logic [WordW-1:0] Iv4 = 32'hC3D2_E1F0;

  // round constants
  localparam logic [WordW-1:0] K0 = 32'h5A82_7999;
  localparam logic [WordW-1:0] K1 = 32'h6ED9_EBA1;
  localparam logic [WordW-1:0] K2 = 32'h8F1B_BCDC;
  localparam logic [WordW-1:0] K3 = 32'hCA62_C1D6;

  localparam logic [RoundW-1:0] LastRound = RoundW'(Rounds - 1);
  localparam logic [RoundW-1:0] Round20   = 7'd20;
  localparam logic [RoundW-1:0] Round40   = 7'd40;
  localparam logic [RoundW-1:0] Round60   = 7'd60;

  // padding
  localparam logic [7:0] PadMark  = 8'h80;
  localparam logic [7:0] PadZero  = 8'h00;
  localparam logic [5:0] LenStart = 6'd56;
  localparam logic [5:0] BlockEnd = 6'd63;
  localparam logic [1:0] LaneLast = 2'd3;

  // digest word numbers
  localparam logic [2:0] WordFirst = 3'd0;
  localparam logic [2:0] WordLast  = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_COMP,
    ST_ADD,
    ST_OUT
  } state_t;

  // sequencer controls to the datapath
  typedef struct packed {
    logic              put;
    logic [7:0]        put_data;
    logic [1:0]        lane;
    logic              load;
    logic              step;
    logic [RoundW-1:0] round;
    logic              add;
    logic              init;
    logic [2:0]        word_sel;
  } ctl_t;

endpackage
`default_nettype wire

### rtl/sha1_in_if.sv
// message byte channel
`default_nettype none
interface sha1_in_if;
  logic       valid;
  logic       ready;
  logic       has_byte;
  logic [7:0] data_byte;
  logic       last;

  modport source (output valid, has_byte, data_byte, last, input ready);
  modport sink (input valid, has_byte, data_byte, last, output ready);
endinterface
`default_nettype wire

### rtl/sha1_out_if.sv
// digest word channel
`default_nettype none
interface sha1_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  word_index;
  logic [31:0] hash_word;
  logic        last_word;

  modport source (output valid, word_index, hash_word, last_word, input ready);
  modport sink (input valid, word_index, hash_word, last_word, output ready);
endinterface
`default_nettype wire

### rtl/sha1_sched.sv
// byte packer and 16-word message schedule shift line
`default_nettype none
module sha1_sched
  import sha1_pkg::*;
(
  input  wire logic             clk,
  input  wire ctl_t             ctl,
  output logic [WordW-1:0]      w
);

  logic [23:0]      acc;
  logic [WordW-1:0] sreg [16];
  logic [WordW-1:0] w_new;
  logic [WordW-1:0] x;

  // next schedule word, w[t+16] from w[t+13], w[t+8], w[t+2], w[t]
  always_comb begin
    x     = sreg[13] ^ sreg[8] ^ sreg[2] ^ sreg[0];
    w_new = {x[WordW-2:0], x[WordW-1]};
  end

  assign w = sreg[0];

  // big-endian byte gathering, a full word shifts into the line
  always_ff @(posedge clk) begin
    if (ctl.put) begin
      if (ctl.lane == LaneLast) begin
        for (int i = 0; i < 15; i++) begin
          sreg[i] <= sreg[i+1];
        end
        sreg[15] <= {acc, ctl.put_data};
      end else begin
        acc <= {acc[15:0], ctl.put_data};
      end
    end else if (ctl.step) begin
      for (int i = 0; i < 15; i++) begin
        sreg[i] <= sreg[i+1];
      end
      sreg[15] <= w_new;
    end
  end

endmodule
`default_nettype wire

### rtl/sha1_round.sv
// shared round unit with working registers and chaining value
`default_nettype none
module sha1_round
  import sha1_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire ctl_t             ctl,
  input  wire logic [WordW-1:0] w,
  output logic [WordW-1:0]      hash_word
);

  logic [WordW-1:0] a, b, c, d, e;
  logic [WordW-1:0] h0, h1, h2, h3, h4;
  logic [WordW-1:0] f, k, t;

  // round function and constant by round group
  always_comb begin
    if (ctl.round < Round20) begin
      f = (b & c) | (~b & d);
      k = K0;
    end else if (ctl.round < Round40) begin
      f = b ^ c ^ d;
      k = K1;
    end else if (ctl.round < Round60) begin
      f = (b & c) | (b & d) | (c & d);
      k = K2;
    end else begin
      f = b ^ c ^ d;
      k = K3;
    end
    t = {a[26:0], a[31:27]} + f + e + k + w;
  end

  // working registers
  always_ff @(posedge clk) begin
    if (rst || ctl.init) begin
      a <= '0;
      b <= '0;
      c <= '0;
      d <= '0;
      e <= '0;
    end else if (ctl.load) begin
      a <= h0;
      b <= h1;
      c <= h2;
      d <= h3;
      e <= h4;
    end else if (ctl.step) begin
      e <= d;
      d <= c;
      c <= {b[1:0], b[31:2]};
      b <= a;
      a <= t;
    end
  end

  // chaining value
  always_ff @(posedge clk) begin
    if (rst || ctl.init) begin
      h0 <= Iv0;
      h1 <= Iv1;
      h2 <= Iv2;
      h3 <= Iv3;
      h4 <= Iv4;
    end else if (ctl.add) begin
      h0 <= h0 + a;
      h1 <= h1 + b;
      h2 <= h2 + c;
      h3 <= h3 + d;
      h4 <= h4 + e;
    end
  end

  // digest word select
  always_comb begin
    case (ctl.word_sel)
      3'd0:    hash_word = h0;
      3'd1:    hash_word = h1;
      3'd2:    hash_word = h2;
      3'd3:    hash_word = h3;
      3'd4:    hash_word = h4;
      default: hash_word = h4;
    endcase
  end

endmodule
`default_nettype wire

### rtl/sha1_ctrl.sv
// sequencer: byte intake, padding, round count and digest output
`default_nettype none
module sha1_ctrl
  import sha1_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  sha1_in_if.sink    msg,
  input  wire logic  out_ready,
  output logic       out_valid,
  output ctl_t       ctl
);

  state_t            state, state_next;
  logic [5:0]        pos;
  logic [63:0]       bit_length;
  logic              padding;
  logic              sent80;
  logic              len_phase;
  logic              finish;
  logic [RoundW-1:0] rc;
  logic [2:0]        widx;
  logic              accept;
  logic              lensel;
  logic              wrap;
  logic              out_done;
  logic [5:0]        len_shift;

  assign msg.ready = (state == ST_IDLE);
  assign accept    = msg.valid && msg.ready;
  assign lensel    = len_phase || (sent80 && pos == LenStart);
  assign wrap      = (pos == BlockEnd);
  assign out_valid = (state == ST_OUT);
  assign out_done  = out_valid && out_ready && (widx == WordLast);
  assign len_shift = {3'd7 - pos[2:0], 3'b000};

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and datapath controls
  always_comb begin
    state_next   = state;
    ctl          = '0;
    ctl.lane     = pos[1:0];
    ctl.round    = rc;
    ctl.word_sel = widx;
    case (state)
      ST_IDLE: begin
        ctl.put      = accept && msg.has_byte;
        ctl.put_data = msg.data_byte;
        if (accept && msg.has_byte && wrap) begin
          ctl.load   = 1'b1;
          state_next = ST_COMP;
        end else if (accept && msg.last) begin
          state_next = ST_PAD;
        end
      end
      ST_PAD: begin
        ctl.put = 1'b1;
        if (!sent80) begin
          ctl.put_data = PadMark;
        end else if (lensel) begin
          ctl.put_data = bit_length[len_shift +: 8];
        end else begin
          ctl.put_data = PadZero;
        end
        if (wrap) begin
          ctl.load   = 1'b1;
          state_next = ST_COMP;
        end
      end
      ST_COMP: begin
        ctl.step = 1'b1;
        if (rc == LastRound) begin
          state_next = ST_ADD;
        end
      end
      ST_ADD: begin
        ctl.add = 1'b1;
        if (finish) begin
          state_next = ST_OUT;
        end else if (padding) begin
          state_next = ST_PAD;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_OUT: begin
        if (out_done) begin
          ctl.init   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // byte position, length and padding flags
  always_ff @(posedge clk) begin
    if (rst || out_done) begin
      pos        <= '0;
      bit_length <= '0;
      padding    <= 1'b0;
      sent80     <= 1'b0;
      len_phase  <= 1'b0;
      finish     <= 1'b0;
    end else begin
      if (ctl.put) begin
        pos <= pos + 6'd1;
      end
      if (accept && msg.has_byte) begin
        bit_length <= bit_length + 64'd8;
      end
      if (accept && msg.last) begin
        padding <= 1'b1;
      end
      if (state == ST_PAD) begin
        sent80 <= 1'b1;
        if (sent80 && lensel) begin
          len_phase <= 1'b1;
          if (wrap) begin
            finish <= 1'b1;
          end
        end
      end
    end
  end

  // round counter
  always_ff @(posedge clk) begin
    if (rst || state != ST_COMP) begin
      rc <= '0;
    end else begin
      rc <= rc + 7'd1;
    end
  end

  // digest word counter
  always_ff @(posedge clk) begin
    if (rst || out_done) begin
      widx <= WordFirst;
    end else if (out_valid && out_ready) begin
      widx <= widx + 3'd1;
    end
  end

endmodule
`default_nettype wire

### rtl/sha1_hash_engine.sv
// sha-1 hash engine: a byte or none per request, five digest words per message
// a byte that does not complete a block leaves the engine ready; one that completes
// a block keeps it busy through load, 80 rounds on one shared round unit and add
// the final request adds one padding byte per cycle plus one or two compressions,
// then five digest words, one per cycle while the sink is ready
// synchronous active-high rst returns chaining value, length and position to start
`default_nettype none
module sha1_hash_engine
  import sha1_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  sha1_in_if.sink    msg,
  sha1_out_if.source digest
);

  ctl_t             ctl;
  logic             out_valid;
  logic [WordW-1:0] w;
  logic [WordW-1:0] hash_word;

  sha1_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .msg       (msg),
    .out_ready (digest.ready),
    .out_valid (out_valid),
    .ctl       (ctl)
  );

  sha1_sched u_sched (
    .clk (clk),
    .ctl (ctl),
    .w   (w)
  );

  sha1_round u_round (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .w         (w),
    .hash_word (hash_word)
  );

  // digest channel
  assign digest.valid      = out_valid;
  assign digest.word_index = ctl.word_sel;
  assign digest.hash_word  = hash_word;
  assign digest.last_word  = (ctl.word_sel == WordLast);

`ifndef ASSERT_OFF
  a_no_intake_during_output: assert property (@(posedge clk) disable iff (rst)
    !(msg.ready && digest.valid))
    else $error("input ready while digest words are pending");

  a_ready_after_digest: assert property (@(posedge clk) disable iff (rst)
    (digest.valid && digest.ready && digest.last_word) |=> msg.ready)
    else $error("engine not ready after final digest word");

  a_word_order: assert property (@(posedge clk) disable iff (rst)
    (digest.valid && digest.ready && !digest.last_word) |=>
      (digest.valid && digest.word_index == $past(digest.word_index) + 3'd1))
    else $error("digest words out of order");
`endif

endmodule
`default_nettype wire

### tb/sha1_digest_checker.sv
// scoreboard for the sha-1 hash engine: predicts digests from byte requests and checks words
`default_nettype none
module sha1_digest_checker
  import sha1_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  sha1_in_if        msg,
  sha1_out_if       digest,
  output int        errors,
  output int        outstanding
);

  localparam logic [31:0] Init0 = 32'h6745_2301;
  localparam logic [31:0] Init1 = 32'hEFCD_AB89;
  localparam logic [31:0] Init2 = 32'h98BA_DCFE;
  localparam logic [31:0] Init3 = 32'h1032_5476;
  localparam logic [31:0] Init4 = 32'hC3D2_E1F0;
  localparam logic [31:0] RoundK0 = 32'h5A82_7999;
  localparam logic [31:0] RoundK1 = 32'h6ED9_EBA1;
  localparam logic [31:0] RoundK2 = 32'h8F1B_BCDC;
  localparam logic [31:0] RoundK3 = 32'hCA62_C1D6;
  localparam logic [7:0]  PadByte = 8'h80;
  localparam logic [5:0]  LenPos  = 6'd56;
  localparam int          ShownMax = 10;

  typedef struct packed {
    logic [2:0]  idx;
    logic [31:0] word;
    logic        tail;
  } digest_word_t;

  logic [31:0]  msg_block [16];
  logic [31:0]  chain [5];
  logic [63:0]  bit_count;
  logic [5:0]   byte_pos;
  digest_word_t due_words [$];
  int           bad_count = 0;

  assign errors = bad_count;

  // back to the state of a fresh message
  function automatic void restart_message();
    for (int i = 0; i < 16; i++) msg_block[i] = '0;
    chain[0] = Init0;
    chain[1] = Init1;
    chain[2] = Init2;
    chain[3] = Init3;
    chain[4] = Init4;
    bit_count = '0;
    byte_pos = '0;
  endfunction

  // 80 rounds over the gathered block, folded into the chaining value
  function automatic void compress_block();
    logic [31:0] w [80];
    logic [31:0] a, b, c, d, e, f, k, t, x;
    for (int i = 0; i < 16; i++) w[i] = msg_block[i];
    for (int i = 16; i < 80; i++) begin
      x = w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16];
      w[i] = {x[30:0], x[31]};
    end
    a = chain[0];
    b = chain[1];
    c = chain[2];
    d = chain[3];
    e = chain[4];
    for (int i = 0; i < 80; i++) begin
      if (i < 20) begin
        f = (b & c) | (~b & d);
        k = RoundK0;
      end else if (i < 40) begin
        f = b ^ c ^ d;
        k = RoundK1;
      end else if (i < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = RoundK2;
      end else begin
        f = b ^ c ^ d;
        k = RoundK3;
      end
      t = {a[26:0], a[31:27]} + f + e + k + w[i];
      e = d;
      d = c;
      c = {b[1:0], b[31:2]};
      b = a;
      a = t;
    end
    chain[0] += a;
    chain[1] += b;
    chain[2] += c;
    chain[3] += d;
    chain[4] += e;
  endfunction

  // big-endian byte placement, compress on a full block
  function automatic void absorb(logic [7:0] b);
    int sh;
    sh = 24 - 8 * int'(byte_pos[1:0]);
    if (byte_pos[1:0] == 2'd0) msg_block[byte_pos[5:2]] = 32'(b) << sh;
    else msg_block[byte_pos[5:2]] |= 32'(b) << sh;
    byte_pos = byte_pos + 6'd1;
    if (byte_pos == 6'd0) compress_block();
  endfunction

  // one accepted request: absorb its byte, pad and queue the digest on last
  function automatic void predict_request(logic hb, logic [7:0] db, logic lst);
    logic [63:0] len;
    if (hb) begin
      absorb(db);
      bit_count += 64'd8;
    end
    if (lst) begin
      len = bit_count;
      absorb(PadByte);
      while (byte_pos != LenPos) absorb(8'h00);
      for (int i = 7; i >= 0; i--) absorb(len[8*i +: 8]);
      for (int i = 0; i < 5; i++) begin
        due_words.push_back('{idx: 3'(i), word: chain[i], tail: (i == 4)});
      end
      restart_message();
    end
  endfunction

  // compare digest words first, then predict from the request of the same edge
  always @(posedge clk) begin
    digest_word_t want;
    if (rst) begin
      restart_message();
      due_words.delete();
    end else begin
      if (digest.valid && digest.ready) begin
        if (due_words.size() == 0) begin
          bad_count++;
          if (bad_count <= ShownMax)
            $display("unexpected digest word: index %0d word %08h last %0b",
                     digest.word_index, digest.hash_word, digest.last_word);
        end else begin
          want = due_words.pop_front();
          if (digest.word_index !== want.idx || digest.hash_word !== want.word ||
              digest.last_word !== want.tail) begin
            bad_count++;
            if (bad_count <= ShownMax)
              $display("digest mismatch: index %0d/%0d word %08h/%08h last %0b/%0b (got/exp)",
                       digest.word_index, want.idx, digest.hash_word, want.word,
                       digest.last_word, want.tail);
          end
        end
      end
      if (msg.valid && msg.ready) predict_request(msg.has_byte, msg.data_byte, msg.last);
    end
    outstanding <= due_words.size();
  end

endmodule
`default_nettype wire

### tb/tb_sha1_hash_engine.sv
// top of the sha-1 hash engine testbench: clock, reset, byte stimulus, digest sink, verdict
`default_nettype none
module tb_sha1_hash_engine;

  localparam int QuietLimit  = 5000;
  localparam int HoldCycles  = 300;
  localparam int RandomItems = 460;
  localparam int DrainCycles = 200;

  logic clk = 1'b0;
  logic rst;
  logic hold_req = 1'b0;
  logic tx_quick = 1'b0;
  int   err_count;
  int   due_count;
  int   items_sent = 0;
  int   quiet_cycles = 0;
  int   border_lens [7] = '{54, 55, 56, 57, 63, 64, 65};

  sha1_in_if  msg_ch ();
  sha1_out_if dig_ch ();

  sha1_hash_engine dut (
    .clk    (clk),
    .rst    (rst),
    .msg    (msg_ch),
    .digest (dig_ch)
  );

  sha1_digest_checker chk (
    .clk         (clk),
    .rst         (rst),
    .msg         (msg_ch),
    .digest      (dig_ch),
    .errors      (err_count),
    .outstanding (due_count)
  );

  always #1 clk = ~clk;

  // byte values with the all-zero and all-one patterns favored
  function automatic logic [7:0] rand_byte();
    int r;
    r = $urandom_range(0, 7);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hFF;
    return 8'($urandom);
  endfunction

  // offer one request after a random gap, none in quick mode, and hold it until accepted
  task automatic send_item(input logic hb, input logic [7:0] db, input logic lst);
    int gap;
    gap = tx_quick ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      msg_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    msg_ch.valid     <= 1'b1;
    msg_ch.has_byte  <= hb;
    msg_ch.data_byte <= db;
    msg_ch.last      <= lst;
    do @(posedge clk); while (!msg_ch.ready);
    if (hb || lst) items_sent++;
  endtask

  // a message of len bytes, with stray idle requests, ended on its byte or apart
  task automatic send_message(input int len, input logic split);
    for (int n = 0; n < len; n++) begin
      if ($urandom_range(0, 11) == 0) send_item(1'b0, rand_byte(), 1'b0);
      send_item(1'b1, rand_byte(), (n == len - 1) && !split);
    end
    if (split || len == 0) send_item(1'b0, rand_byte(), 1'b1);
  endtask

  // wait for every digest word, then let the engine settle
  task automatic wait_drained();
    @(posedge clk);
    while (due_count != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // every 16 words the sink picks no gap or a random gap; w never stays below zero
  task automatic tx_quick_rx_pick(output int w);
    w = ($urandom_range(0, 2) == 0) ? -1 : $urandom_range(0, 15);
    if (w < 0) w = 0;
  endtask

  // digest sink: random stalls, quiet stretches, and one long hold-off on request
  initial begin
    int w;
    int rx_items;
    rx_items = 0;
    dig_ch.ready <= 1'b0;
    forever begin
      if (hold_req) begin
        dig_ch.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        if (rx_items % 16 == 0) tx_quick_rx_pick(w);
        else w = (w < 0) ? 0 : $urandom_range(0, 15);
        rx_items++;
        if (w > 0) begin
          dig_ch.ready <= 1'b0;
          repeat (w) @(posedge clk);
        end
        dig_ch.ready <= 1'b1;
        do @(posedge clk); while (!dig_ch.valid && !hold_req);
      end
    end
  end

  // stimulus
  initial begin
    int len;
    int pick;
    int goal;
    int msgs;
    rst              <= 1'b1;
    msg_ch.valid     <= 1'b0;
    msg_ch.has_byte  <= 1'b0;
    msg_ch.data_byte <= 8'h00;
    msg_ch.last      <= 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // empty message
    send_item(1'b0, 8'h00, 1'b1);
    // idle request, then "abc" ended on its last byte
    send_item(1'b0, 8'hFF, 1'b0);
    send_item(1'b1, 8'h61, 1'b0);
    send_item(1'b1, 8'h62, 1'b0);
    send_item(1'b1, 8'h63, 1'b1);
    // extreme bytes ended by an empty last request
    send_item(1'b1, 8'h00, 1'b0);
    send_item(1'b1, 8'hFF, 1'b0);
    send_item(1'b0, 8'hFF, 1'b1);
    // single byte messages, then a two-byte one
    send_item(1'b1, 8'hFF, 1'b1);
    send_item(1'b1, 8'h00, 1'b1);
    send_item(1'b1, 8'h80, 1'b0);
    send_item(1'b1, 8'h7F, 1'b1);

    // sink holds off while short messages keep coming, so the input backs up
    hold_req = 1'b1;
    tx_quick = 1'b1;
    for (int m = 0; m < 3; m++) send_message(3, 1'b0);
    // sender pause until every digest word is out
    wait_drained();

    goal = items_sent + RandomItems;
    msgs = 0;
    while (items_sent < goal) begin
      tx_quick = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 9);
      if (pick <= 5) len = $urandom_range(0, 12);
      else if (pick <= 7) len = border_lens[$urandom_range(0, 6)];
      else if (pick == 8) len = $urandom_range(0, 130);
      else len = $urandom_range(118, 121);
      send_message(len, 1'($urandom_range(0, 1)));
      msgs++;
      if (msgs == 6) wait_drained();
    end

    msg_ch.valid <= 1'b0;
    wait_drained();
    if (err_count == 0 && due_count == 0) begin
      $display("tb_sha1_hash_engine: clean");
    end else begin
      $display("tb_sha1_hash_engine: errors");
    end
    $finish;
  end

  // watchdog on cycles with no accepted request on either channel
  always @(posedge clk) begin
    if (!rst) begin
      if ((msg_ch.valid && msg_ch.ready) || (dig_ch.valid && dig_ch.ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QuietLimit) begin
        $display("tb_sha1_hash_engine: errors");
        $finish;
      end
    end
  end

endmodule
`default_nettype wire

### files.f
rtl/sha1_pkg.sv
rtl/sha1_in_if.sv
rtl/sha1_out_if.sv
rtl/sha1_sched.sv
rtl/sha1_round.sv
rtl/sha1_ctrl.sv
rtl/sha1_hash_engine.sv
tb/sha1_digest_checker.sv
tb/tb_sha1_hash_engine.sv
